// File: rtl/variable_length_record_stack_defines.svh
// Assertion macros shared by the checker of the record stack.
`ifndef VARIABLE_LENGTH_RECORD_STACK_DEFINES_SVH
`define VARIABLE_LENGTH_RECORD_STACK_DEFINES_SVH

// Same-cycle implication, sampled on aclk, quiet while aresetn is low.
`define VLRS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vlrs port check failed");

// Next-cycle implication, sampled on aclk, quiet while aresetn is low.
`define VLRS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vlrs port check failed");

`endif

// File: rtl/vlrs_pkg.sv
package vlrs_pkg;

    localparam int STACK_BYTES_DEF = 1024;
    localparam int LEN_BYTES_DEF   = 4;
    localparam int MAX_RECORD_DEF  = 64;

    localparam int ACT_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 7;
    localparam int FREE_W    = 11;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    // Controller to datapath
    typedef struct packed {
        logic take;      // latch the input item
        logic exec;      // perform the latched action
        logic trail;     // write one length trailer byte
        logic len_eval;  // evaluate the trailer just read
        logic stream;    // emit one record byte
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_push;
        logic is_read;
        logic out_free;
        logic commit;
        logic empty;
        logic trail_last;
        logic n_zero;
        logic last_byte;
    } sts_t;

endpackage

// File: rtl/vlrs_ctrl.sv
module vlrs_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  vlrs_pkg::sts_t sts,
    output vlrs_pkg::cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EXEC   = 5'b00010,
        ST_TRAIL  = 5'b00100,
        ST_LEN    = 5'b01000,
        ST_STREAM = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // wait for a free output slot, every action may emit here
                if (sts.out_free) begin
                    cmd.exec = 1'b1;
                    if (sts.is_push) begin
                        state_next = sts.commit ? ST_TRAIL : ST_IDLE;
                    end else if (sts.is_read && !sts.empty) begin
                        state_next = ST_LEN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_TRAIL: begin
                cmd.trail = 1'b1;
                if (sts.trail_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LEN: begin
                // output slot is still free: the read step emitted nothing
                cmd.len_eval = 1'b1;
                state_next   = sts.n_zero ? ST_IDLE : ST_STREAM;
            end
            ST_STREAM: begin
                if (sts.out_free) begin
                    cmd.stream = 1'b1;
                    if (sts.last_byte) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/vlrs_dpath.sv
module vlrs_dpath #(
    parameter int STACK_BYTES = vlrs_pkg::STACK_BYTES_DEF,
    parameter int LEN_BYTES   = vlrs_pkg::LEN_BYTES_DEF,
    parameter int MAX_RECORD  = vlrs_pkg::MAX_RECORD_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [vlrs_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [vlrs_pkg::ACT_W-1:0]      s_tuser,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [vlrs_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast,
    input  vlrs_pkg::cmd_t                  cmd,
    output vlrs_pkg::sts_t                  sts
);

    localparam int TW = $clog2(STACK_BYTES + 1);
    localparam int SW = TW + 1;
    localparam int AW = $clog2(STACK_BYTES);
    localparam int IW = (LEN_BYTES > 1) ? $clog2(LEN_BYTES) : 1;
    localparam int LW = vlrs_pkg::LEN_W;
    localparam int BW = vlrs_pkg::BYTE_W;
    localparam int FW = vlrs_pkg::FREE_W;

    // byte store
    logic [BW-1:0] mem [STACK_BYTES];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [BW-1:0] mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;
    logic [BW-1:0] rd_q;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_q <= mem[mem_ra];
        end
    end

    // latched input item
    vlrs_pkg::action_t act_reg;
    logic [BW-1:0]     data_reg;
    logic [LW-1:0]     elen_reg;
    logic [LW-1:0]     want_reg;

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            act_reg  <= vlrs_pkg::action_t'(s_tuser);
            data_reg <= s_tdata[7:0];
            elen_reg <= s_tdata[14:8];
            want_reg <= s_tdata[21:15];
        end
    end

    // stack and push state
    logic [TW-1:0] top_reg,        top_next;
    logic          pact_reg,       pact_next;
    logic          prej_reg,       prej_next;
    logic [LW-1:0] plen_reg,       plen_next;
    logic [LW-1:0] pcnt_reg,       pcnt_next;
    // trailer writer, read and stream state
    logic [AW-1:0] tr_base_reg,    tr_base_next;
    logic [LW-1:0] tr_len_reg,     tr_len_next;
    logic [IW-1:0] tr_idx_reg,     tr_idx_next;
    logic [TW-1:0] below_reg,      below_next;
    logic [AW-1:0] str_addr_reg,   str_addr_next;
    logic [LW-1:0] str_left_reg,   str_left_next;
    // result register
    logic          m_valid_reg,    m_valid_next;
    logic [BW-1:0] o_byte_reg;
    logic          o_valid_reg;
    logic          o_last_reg;
    logic          o_ok_reg;
    logic          o_empty_reg;
    logic [FW-1:0] o_free_reg;

    // push step terms
    logic          p_start;
    logic [LW-1:0] len_eff;
    logic [LW-1:0] cnt_eff;
    logic [SW-1:0] fit_sum;
    logic          rej_new;
    logic          rej_eff;
    logic          p_wr;
    logic [LW-1:0] cnt_inc;
    logic          p_done;
    logic          p_commit;
    // read step terms
    logic [TW-1:0] below_calc;
    logic [BW-1:0] rec_cap;
    logic [LW-1:0] rec_sel;
    logic [TW-1:0] base_calc;
    logic [LW-1:0] n_calc;
    // result being emitted
    logic          emit;
    logic [BW-1:0] e_byte;
    logic          e_valid;
    logic          e_last;
    logic          e_ok;
    logic [31:0]   free_w;

    always_comb begin
        p_start  = !pact_reg;
        len_eff  = p_start ? elen_reg : plen_reg;
        cnt_eff  = p_start ? '0 : pcnt_reg;
        fit_sum  = {1'b0, top_reg} + SW'(len_eff) + SW'(LEN_BYTES);
        rej_new  = (len_eff > LW'(MAX_RECORD)) || (fit_sum > SW'(STACK_BYTES));
        rej_eff  = p_start ? rej_new : prej_reg;
        p_wr     = cnt_eff < len_eff;
        cnt_inc  = p_wr ? cnt_eff + LW'(1) : cnt_eff;
        p_done   = cnt_inc >= len_eff;
        p_commit = p_done && !rej_eff;

        below_calc = (top_reg >= TW'(LEN_BYTES)) ? top_reg - TW'(LEN_BYTES) : '0;
        // only the low trailer byte can be nonzero, lengths fit in it
        rec_cap    = (rd_q > BW'(MAX_RECORD)) ? BW'(MAX_RECORD) : rd_q;
        rec_sel    = (32'(rec_cap) > 32'(below_reg)) ? LW'(below_reg) : LW'(rec_cap);
        base_calc  = below_reg - TW'(rec_sel);
        n_calc     = (want_reg < rec_sel) ? want_reg : rec_sel;
    end

    always_comb begin
        top_next      = top_reg;
        pact_next     = pact_reg;
        prej_next     = prej_reg;
        plen_next     = plen_reg;
        pcnt_next     = pcnt_reg;
        tr_base_next  = tr_base_reg;
        tr_len_next   = tr_len_reg;
        tr_idx_next   = tr_idx_reg;
        below_next    = below_reg;
        str_addr_next = str_addr_reg;
        str_left_next = str_left_reg;
        mem_we        = 1'b0;
        mem_wa        = '0;
        mem_wd        = '0;
        mem_re        = 1'b0;
        mem_ra        = '0;
        emit          = 1'b0;
        e_byte        = '0;
        e_valid       = 1'b0;
        e_last        = 1'b1;
        e_ok          = 1'b0;

        if (cmd.exec) begin
            case (act_reg)
                vlrs_pkg::ACT_PUSH: begin
                    pact_next = !p_done;
                    prej_next = p_done ? 1'b0 : rej_eff;
                    pcnt_next = p_done ? '0 : cnt_inc;
                    plen_next = len_eff;
                    if (p_wr && !rej_eff) begin
                        mem_we = 1'b1;
                        mem_wa = AW'(top_reg + TW'(cnt_eff));
                        mem_wd = data_reg;
                    end
                    if (p_commit) begin
                        top_next     = top_reg + TW'(len_eff) + TW'(LEN_BYTES);
                        tr_base_next = AW'(top_reg + TW'(len_eff));
                        tr_len_next  = len_eff;
                        tr_idx_next  = '0;
                    end
                    emit = 1'b1;
                    e_ok = !rej_eff;
                end
                vlrs_pkg::ACT_POP, vlrs_pkg::ACT_PEEK: begin
                    pact_next = 1'b0;
                    prej_next = 1'b0;
                    pcnt_next = '0;
                    if (top_reg == '0) begin
                        emit = 1'b1;
                    end else begin
                        mem_re     = 1'b1;
                        mem_ra     = AW'(below_calc);
                        below_next = below_calc;
                    end
                end
                vlrs_pkg::ACT_CLEAR: begin
                    pact_next = 1'b0;
                    prej_next = 1'b0;
                    pcnt_next = '0;
                    top_next  = '0;
                    emit      = 1'b1;
                    e_ok      = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (cmd.trail) begin
            mem_we      = 1'b1;
            mem_wa      = AW'(tr_base_reg + AW'(tr_idx_reg));
            mem_wd      = (tr_idx_reg == '0) ? BW'(tr_len_reg) : '0;
            tr_idx_next = tr_idx_reg + IW'(1);
        end

        if (cmd.len_eval) begin
            if (act_reg == vlrs_pkg::ACT_POP) begin
                top_next = base_calc;
            end
            if (n_calc == '0) begin
                emit = 1'b1;
                e_ok = 1'b1;
            end else begin
                mem_re        = 1'b1;
                mem_ra        = AW'(base_calc);
                str_addr_next = AW'(base_calc) + AW'(1);
                str_left_next = n_calc;
            end
        end

        if (cmd.stream) begin
            emit          = 1'b1;
            e_byte        = rd_q;
            e_valid       = 1'b1;
            e_ok          = 1'b1;
            e_last        = (str_left_reg == LW'(1));
            str_left_next = str_left_reg - LW'(1);
            if (str_left_reg != LW'(1)) begin
                mem_re        = 1'b1;
                mem_ra        = str_addr_reg;
                str_addr_next = str_addr_reg + AW'(1);
            end
        end

        m_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
        free_w       = 32'(STACK_BYTES) - 32'(top_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg     <= '0;
            pact_reg    <= 1'b0;
            prej_reg    <= 1'b0;
            plen_reg    <= '0;
            pcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            top_reg     <= top_next;
            pact_reg    <= pact_next;
            prej_reg    <= prej_next;
            plen_reg    <= plen_next;
            pcnt_reg    <= pcnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tr_base_reg  <= tr_base_next;
        tr_len_reg   <= tr_len_next;
        tr_idx_reg   <= tr_idx_next;
        below_reg    <= below_next;
        str_addr_reg <= str_addr_next;
        str_left_reg <= str_left_next;
        if (emit) begin
            o_byte_reg  <= e_byte;
            o_valid_reg <= e_valid;
            o_last_reg  <= e_last;
            o_ok_reg    <= e_ok;
            o_empty_reg <= (top_next == '0);
            o_free_reg  <= free_w[FW-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, o_free_reg, o_empty_reg, o_ok_reg, o_byte_reg};
    assign m_tuser  = o_valid_reg;
    assign m_tlast  = o_last_reg;

    always_comb begin
        sts.is_push    = (act_reg == vlrs_pkg::ACT_PUSH);
        sts.is_read    = (act_reg == vlrs_pkg::ACT_POP) || (act_reg == vlrs_pkg::ACT_PEEK);
        sts.out_free   = !m_valid_reg || m_tready;
        sts.commit     = p_commit;
        sts.empty      = (top_reg == '0);
        sts.trail_last = (tr_idx_reg == IW'(LEN_BYTES - 1));
        sts.n_zero     = (n_calc == '0);
        sts.last_byte  = (str_left_reg == LW'(1));
    end

endmodule

// File: rtl/variable_length_record_stack.sv
// Channel   Dir  Ports                               Contents
// s_        in   s_tvalid s_tready s_tdata s_tuser   one command item (push byte/pop/peek/clear)
// m_        out  m_tvalid m_tready m_tdata m_tuser   one result item, m_tlast on the final one
//                m_tlast
// Steps: a push byte that completes a record adds LEN_BYTES trailer writes; pop/peek
//   read the trailer, then stream the n bytes returned, and answer from the execute step on an empty stack;
//   clear answers from the execute step. The byte store has a single write/read port and a
//   registered read.
// Reset: aresetn synchronous, active low; empties the stack. Store contents are not cleared.
// Stalls: a result waits in the output register; a held m_tready pauses the step that
//   needs to emit next, while s_tready is high only between items.
module variable_length_record_stack #(
    parameter int STACK_BYTES = vlrs_pkg::STACK_BYTES_DEF,
    parameter int LEN_BYTES   = vlrs_pkg::LEN_BYTES_DEF,
    parameter int MAX_RECORD  = vlrs_pkg::MAX_RECORD_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // data_byte[7:0], elem_len[14:8], want_len[21:15], zero fill [23:22]
    input  logic [vlrs_pkg::S_TDATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [vlrs_pkg::ACT_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_byte[7:0], ok[8], empty_res[9], free_bytes[20:10], zero fill [23:21]
    output logic [vlrs_pkg::M_TDATA_W-1:0]  m_tdata,
    // byte_valid[0]
    output logic                            m_tuser,
    output logic                            m_tlast
);

    vlrs_pkg::cmd_t cmd;
    vlrs_pkg::sts_t sts;

    // Sequence each item: accept, execute, then trailer writes or the read-out loop.
    vlrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the byte store, stack pointer, push tracking and result register.
    vlrs_dpath #(
        .STACK_BYTES (STACK_BYTES),
        .LEN_BYTES   (LEN_BYTES),
        .MAX_RECORD  (MAX_RECORD)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// File: rtl/vlrs_checker.sv
`include "variable_length_record_stack_defines.svh"

module vlrs_checker #(
    parameter int STACK_BYTES = vlrs_pkg::STACK_BYTES_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [vlrs_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);

    localparam logic [vlrs_pkg::FREE_W-1:0] FREE_FULL = vlrs_pkg::FREE_W'(STACK_BYTES);

    // a waiting result stays offered
    `VLRS_ASSERT_NXT(a_result_held, m_tvalid && !m_tready, m_tvalid)
    // one item at a time: no accept in the cycle after an accept
    `VLRS_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready)
    // a status-only result is the last one and carries a zero byte
    `VLRS_ASSERT_IMP(a_status_last, m_tvalid && !m_tuser, m_tlast && (m_tdata[7:0] == 8'd0))
    // record bytes only come with success
    `VLRS_ASSERT_IMP(a_data_ok, m_tvalid && m_tuser, m_tdata[8])
    // an empty stack reports the whole store free
    `VLRS_ASSERT_IMP(a_empty_free, m_tvalid && m_tdata[9], m_tdata[20:10] == FREE_FULL)

endmodule

bind variable_length_record_stack vlrs_checker #(.STACK_BYTES(STACK_BYTES)) u_vlrs_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import vlrs_pkg::*;

    localparam int STORE_BYTES = STACK_BYTES_DEF;
    localparam int TRAILER_LEN = LEN_BYTES_DEF;
    localparam int RECORD_MAX  = MAX_RECORD_DEF;
    // Generous ceiling: long records and heavy output stalls together stay far below this.
    localparam int CYCLE_LIMIT = 2_000_000;
    // Longest step is a pop or peek of a full record.
    localparam int TAIL_CYCLES = 3 + RECORD_MAX + 16;

    // One expected result item, field by field.
    typedef struct {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        is_last;
        logic        ok;
        logic        empty_res;
        logic [10:0] free_bytes;
    } stack_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // data_byte[7:0], elem_len[14:8], want_len[21:15], zero fill [23:22]
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // action[1:0]
    logic [ACT_W-1:0]     s_tuser  = ACT_PUSH;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // out_byte[7:0], ok[8], empty_res[9], free_bytes[20:10], zero fill [23:21]
    logic [M_TDATA_W-1:0] m_tdata;
    // byte_valid[0]
    logic                 m_tuser;
    logic                 m_tlast;

    // Predicted contents of the byte store and the push bookkeeping.
    logic [7:0] store_image [STORE_BYTES];
    int         top_ptr;
    bit         rec_open;
    bit         rec_refused;
    int         rec_len;
    int         rec_fill;

    stack_result_t pending_results [$];

    int error_count    = 0;
    int items_sent     = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int recv_hold_left = 0;

    variable_length_record_stack dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Queue one expected result; emptiness and free space reflect the state after the step.
    function automatic void add_result(logic [7:0] b, logic valid, logic lst, logic okb);
        stack_result_t r;
        r.out_byte   = b;
        r.byte_valid = valid;
        r.is_last    = lst;
        r.ok         = okb;
        r.empty_res  = (top_ptr == 0);
        r.free_bytes = 11'(STORE_BYTES - top_ptr);
        pending_results.push_back(r);
    endfunction

    // Advance the predicted stack by one accepted item and queue what it must produce.
    function automatic void compute_stack_results(action_t act, logic [7:0] data,
                                                  logic [6:0] elen, logic [6:0] want);
        int  below;
        int  stored;
        int  base;
        int  n;
        logic okb;
        if (act == ACT_PUSH) begin
            // First byte of a record: latch its length and decide on space.
            if (!rec_open) begin
                rec_len     = int'(elen);
                rec_fill    = 0;
                rec_refused = (rec_len > RECORD_MAX) ||
                              (top_ptr + rec_len + TRAILER_LEN > STORE_BYTES);
                rec_open    = 1'b1;
            end
            okb = !rec_refused;
            if (rec_fill < rec_len) begin
                if (!rec_refused)
                    store_image[top_ptr + rec_fill] = data;
                rec_fill++;
            end
            // Record done: a refused one is just dropped, a good one gets its trailer.
            if (rec_fill >= rec_len) begin
                if (!rec_refused) begin
                    for (int i = 0; i < TRAILER_LEN; i++)
                        store_image[top_ptr + rec_len + i] = 8'((rec_len >> (8 * i)) & 'hFF);
                    top_ptr += rec_len + TRAILER_LEN;
                end
                rec_open    = 1'b0;
                rec_refused = 1'b0;
                rec_fill    = 0;
            end
            add_result(8'h00, 1'b0, 1'b1, okb);
            return;
        end
        // Any other action drops an unfinished push first.
        rec_open    = 1'b0;
        rec_refused = 1'b0;
        rec_fill    = 0;
        if (act == ACT_CLEAR) begin
            top_ptr = 0;
            add_result(8'h00, 1'b0, 1'b1, 1'b1);
        end else if (top_ptr == 0) begin
            add_result(8'h00, 1'b0, 1'b1, 1'b0);
        end else begin
            below  = top_ptr - TRAILER_LEN;
            stored = 0;
            for (int i = 0; i < TRAILER_LEN; i++)
                stored |= int'(store_image[below + i]) << (8 * i);
            if (stored > RECORD_MAX)
                stored = RECORD_MAX;
            if (stored > below)
                stored = below;
            base = below - stored;
            n    = (int'(want) < stored) ? int'(want) : stored;
            if (act == ACT_POP)
                top_ptr = base;
            if (n == 0) begin
                add_result(8'h00, 1'b0, 1'b1, 1'b1);
            end else begin
                for (int i = 0; i < n; i++)
                    add_result(store_image[base + i], 1'b1, (i == n - 1), 1'b1);
            end
        end
    endfunction

    // Offer one item, hold it until taken, then predict. Entered and left at a falling edge.
    task automatic send_item(action_t act, logic [7:0] data, logic [6:0] elen,
                             logic [6:0] want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, want, elen, data};
        do @(posedge aclk); while (!s_tready);
        compute_stack_results(act, data, elen, want);
        items_sent++;
        @(negedge aclk);
    endtask

    // Push a record of length len, but stop after cut bytes (cut < len abandons it).
    // Only the first byte's elem_len counts; the rest carry noise there.
    task automatic push_record(int len, int cut);
        int count;
        count = (len == 0) ? 1 : cut;
        for (int i = 0; i < count; i++)
            send_item(ACT_PUSH, 8'($urandom_range(255)),
                      (i == 0) ? 7'(len) : 7'($urandom_range(127)),
                      7'($urandom_range(127)));
    endtask

    // Pop, peek or clear with random filler in the unused fields.
    task automatic send_command(action_t act, int want);
        send_item(act, 8'($urandom_range(255)), 7'($urandom_range(127)), 7'(want));
    endtask

    // Hold the sender until every expected result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_results.size() != 0)
            @(negedge aclk);
    endtask

    // Empty stack, zero-length records, partial reads, oversized and abandoned pushes.
    task automatic test_directed_cases();
        send_idle_pct = 37;
        recv_idle_pct = 70;
        send_command(ACT_POP, 64);
        send_command(ACT_PEEK, 0);
        send_command(ACT_CLEAR, 5);
        send_item(ACT_PUSH, 8'hFF, 7'd0, 7'd127);
        send_command(ACT_PEEK, 127);
        send_item(ACT_PUSH, 8'h00, 7'd3, 7'd0);
        send_item(ACT_PUSH, 8'hFF, 7'd127, 7'd127);
        send_item(ACT_PUSH, 8'h5A, 7'd0, 7'd64);
        send_command(ACT_PEEK, 0);
        send_command(ACT_PEEK, 2);
        send_command(ACT_PEEK, 64);
        // Oversized length: refused, then dropped by the pop that follows.
        send_item(ACT_PUSH, 8'hA5, 7'd127, 7'd0);
        send_item(ACT_PUSH, 8'h3C, 7'd0, 7'd0);
        send_command(ACT_POP, 127);
        // Abandon a good record halfway through.
        send_item(ACT_PUSH, 8'h81, 7'd5, 7'd0);
        send_item(ACT_PUSH, 8'h7E, 7'd5, 7'd0);
        send_command(ACT_POP, 64);
        send_item(ACT_PUSH, 8'h11, 7'd65, 7'd0);
        send_command(ACT_CLEAR, 0);
        send_command(ACT_POP, 1);
        wait_drained();
    endtask

    // Block the receiver for a long stretch while the sender keeps offering items.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        recv_hold_left = 400;
        push_record(12, 12);
        for (int k = 0; k < 6; k++)
            send_command(ACT_PEEK, 64);
        push_record(2, 2);
        send_command(ACT_POP, 64);
        wait_drained();
    endtask

    // Mostly well-formed records and reads with random content, plus noise.
    task automatic run_traffic(int count);
        int stop_at;
        int pick;
        int len;
        int cut;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    len = $urandom_range(12);
                else if (pick < 92)
                    len = $urandom_range(RECORD_MAX, 13);
                else
                    len = $urandom_range(127, RECORD_MAX + 1);
                cut = len;
                // Oversized records are mostly cut short to keep the run brisk.
                if (len > RECORD_MAX && $urandom_range(3) != 0)
                    cut = $urandom_range(4, 1);
                else if (len > 1 && $urandom_range(9) == 0)
                    cut = $urandom_range(len - 1, 1);
                push_record(len, cut);
                // A cut record must be ended by something other than a push.
                if (len != 0 && cut < len)
                    send_command(action_t'($urandom_range(3, 1)), $urandom_range(127));
            end else if (pick < 70) begin
                send_command(ACT_POP, ($urandom_range(9) == 0) ? $urandom_range(127, 65)
                                                              : $urandom_range(64));
            end else if (pick < 94) begin
                send_command(ACT_PEEK, ($urandom_range(9) == 0) ? $urandom_range(127, 65)
                                                               : $urandom_range(64));
            end else begin
                send_command(ACT_CLEAR, $urandom_range(127));
            end
        end
    endtask

    // Three idle mixes: slow receiver, slow sender, then full speed.
    task automatic test_random_traffic();
        send_idle_pct = 37;
        recv_idle_pct = 70;
        run_traffic(35);
        send_idle_pct = 70;
        recv_idle_pct = 37;
        run_traffic(35);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_traffic(35);
        wait_drained();
    endtask

    // Receiver: a counted hold-off wins, otherwise accept at random.
    always @(negedge aclk) begin
        if (recv_hold_left > 0) begin
            m_tready <= 1'b0;
            recv_hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare every taken result against the oldest expectation.
    always @(posedge aclk) begin : result_check
        stack_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: out_byte %0d", m_tdata[7:0]);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata[7:0] !== exp_r.out_byte) begin
                    $error("out_byte: expected %0d, got %0d", exp_r.out_byte, m_tdata[7:0]);
                    error_count++;
                end
                if (m_tuser !== exp_r.byte_valid) begin
                    $error("byte_valid: expected %0d, got %0d", exp_r.byte_valid, m_tuser);
                    error_count++;
                end
                if (m_tlast !== exp_r.is_last) begin
                    $error("last: expected %0d, got %0d", exp_r.is_last, m_tlast);
                    error_count++;
                end
                if (m_tdata[8] !== exp_r.ok) begin
                    $error("ok: expected %0d, got %0d", exp_r.ok, m_tdata[8]);
                    error_count++;
                end
                if (m_tdata[9] !== exp_r.empty_res) begin
                    $error("empty_res: expected %0d, got %0d", exp_r.empty_res, m_tdata[9]);
                    error_count++;
                end
                if (m_tdata[20:10] !== exp_r.free_bytes) begin
                    $error("free_bytes: expected %0d, got %0d", exp_r.free_bytes,
                           m_tdata[20:10]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if the traffic never completes.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("variable_length_record_stack: mismatch");
        $finish;
    end

    initial begin : sequencer
        top_ptr     = 0;
        rec_open    = 1'b0;
        rec_refused = 1'b0;
        rec_len     = 0;
        rec_fill    = 0;
        // Hold reset, then release it away from the sampling edge.
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();
        // Let trailer writes and any stray output settle before judging.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("variable_length_record_stack: match");
        else
            $display("variable_length_record_stack: mismatch");
        $finish;
    end

endmodule
